### hdl/atrp_pkg.sv
// Shared types and constants for the AT response byte parser.
// Holds the word structs, the character class codes and the buffer sizing.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package atrp_pkg;

    // Message buffer depth and the width of the write index that spans it.
    localparam int BUF_DEPTH = 256;
    localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
    localparam int ADDR_W    = 8;

    // Depth of the queue between the classifier and the parser core.
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Request codes.
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Outcome codes reported with every result word.
    localparam logic [2:0] OC_PENDING  = 3'd0;
    localparam logic [2:0] OC_OK       = 3'd1;
    localparam logic [2:0] OC_ERROR    = 3'd2;
    localparam logic [2:0] OC_OVERFLOW = 3'd3;
    localparam logic [2:0] OC_MESSAGE  = 3'd4;

    // Character classes found by the classifier.
    localparam int CC_W = 4;
    localparam logic [CC_W-1:0] CC_OTHER = 4'd0;
    localparam logic [CC_W-1:0] CC_O     = 4'd1;
    localparam logic [CC_W-1:0] CC_K     = 4'd2;
    localparam logic [CC_W-1:0] CC_E     = 4'd3;
    localparam logic [CC_W-1:0] CC_R     = 4'd4;
    localparam logic [CC_W-1:0] CC_PLUS  = 4'd5;
    localparam logic [CC_W-1:0] CC_I     = 4'd6;
    localparam logic [CC_W-1:0] CC_P     = 4'd7;
    localparam logic [CC_W-1:0] CC_D     = 4'd8;
    localparam logic [CC_W-1:0] CC_DASH  = 4'd9;

    // Input word.
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } cmd_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0]        echo_byte;
        logic              echo_valid;
        logic [2:0]        outcome;
        logic              store_we;
        logic [ADDR_W-1:0] store_addr;
        logic [7:0]        store_byte;
        logic              term_we;
        logic [ADDR_W-1:0] term_addr;
    } res_word_t;

    // Classified word held in the queue.
    typedef struct packed {
        logic            clear;
        logic [7:0]      data;
        logic [CC_W-1:0] cls;
    } class_word_t;

endpackage

`default_nettype wire

### hdl/atrp_front.sv
// Front end of the AT response parser: classifies each incoming word.
// Maps the received character onto a small class code for the parser core.
// Depends on atrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atrp_front (
    input  wire atrp_pkg::cmd_word_t   cmd,
    output atrp_pkg::class_word_t      cls_word
);

    // Decode the character into its class and flag clear words; the character is passed on for clear words too.
    always_comb
    begin
        cls_word.clear = (cmd.req_type == atrp_pkg::REQ_CLEAR);
        cls_word.data  = cmd.rx_byte;
        unique case (cmd.rx_byte)
            8'h4F:   cls_word.cls = atrp_pkg::CC_O;
            8'h4B:   cls_word.cls = atrp_pkg::CC_K;
            8'h45:   cls_word.cls = atrp_pkg::CC_E;
            8'h52:   cls_word.cls = atrp_pkg::CC_R;
            8'h2B:   cls_word.cls = atrp_pkg::CC_PLUS;
            8'h49:   cls_word.cls = atrp_pkg::CC_I;
            8'h50:   cls_word.cls = atrp_pkg::CC_P;
            8'h44:   cls_word.cls = atrp_pkg::CC_D;
            8'h2D:   cls_word.cls = atrp_pkg::CC_DASH;
            default: cls_word.cls = atrp_pkg::CC_OTHER;
        endcase
    end

endmodule

`default_nettype wire

### hdl/atrp_queue.sv
// Short queue between the classifier and the parser core.
// A small register array with read and write pointers and a fill count.
// Depends on atrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atrp_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  wire atrp_pkg::class_word_t   push_word,
    output logic                         full,
    input  wire                          pop,
    output logic                         head_valid,
    output atrp_pkg::class_word_t        head_word
);

    atrp_pkg::class_word_t               mem [atrp_pkg::QDEPTH];
    logic [atrp_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [atrp_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [atrp_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                                do_push, do_pop;

    assign full       = (count_reg == atrp_pkg::QCNT_W'(atrp_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count update; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == atrp_pkg::QPTR_W'(atrp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == atrp_pkg::QPTR_W'(atrp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

### hdl/atrp_back.sv
// Parser core of the AT response parser: holds the parse state and write index.
// Applies one classified word per cycle while the result word is not stalled, and registers the result word.
// Depends on atrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atrp_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          head_valid,
    input  wire atrp_pkg::class_word_t   head_word,
    output logic                         pop,
    output logic                         res_valid,
    input  wire                          res_stall,
    output atrp_pkg::res_word_t          res
);

    // Parse state codes.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_O     = 4'd1;
    localparam logic [3:0] ST_OK    = 4'd2;
    localparam logic [3:0] ST_E     = 4'd3;
    localparam logic [3:0] ST_ER    = 4'd4;
    localparam logic [3:0] ST_ERR   = 4'd5;
    localparam logic [3:0] ST_ERRO  = 4'd6;
    localparam logic [3:0] ST_ERROR = 4'd7;
    localparam logic [3:0] ST_PLUS  = 4'd8;
    localparam logic [3:0] ST_PI    = 4'd9;
    localparam logic [3:0] ST_PIP   = 4'd10;
    localparam logic [3:0] ST_DATA  = 4'd11;
    localparam logic [3:0] ST_R_OK  = 4'd12;
    localparam logic [3:0] ST_R_ERR = 4'd13;
    localparam logic [3:0] ST_R_OVF = 4'd14;
    localparam logic [3:0] ST_R_MSG = 4'd15;

    logic [3:0]                   state_reg, state_next;
    logic [atrp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [atrp_pkg::IDX_W-1:0]   idx_inc;
    logic [3:0]                   st_mid;
    logic                         res_valid_reg;
    atrp_pkg::res_word_t          res_reg, res_next;
    logic                         out_free;

    assign out_free  = !res_valid_reg || !res_stall;
    assign pop       = head_valid && out_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign idx_inc   = idx_reg + 1'b1;

    // One parser step on the head word.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        st_mid     = state_reg;
        res_next   = '0;
        if (head_word.clear)
        begin
            state_next = ST_IDLE;
        end
        else
        begin
            res_next.echo_byte  = head_word.data;
            res_next.echo_valid = 1'b1;
            if (state_reg < ST_R_OK)
            begin
                // Act on the held state first.
                if (state_reg == ST_OK)
                begin
                    st_mid = ST_R_OK;
                end
                else if (state_reg == ST_ERROR)
                begin
                    st_mid = ST_R_ERR;
                end
                else if (state_reg == ST_DATA)
                begin
                    res_next.store_we   = 1'b1;
                    res_next.store_addr = atrp_pkg::ADDR_W'(idx_reg);
                    res_next.store_byte = head_word.data;
                    if (idx_inc == atrp_pkg::IDX_W'(atrp_pkg::BUF_DEPTH))
                    begin
                        st_mid   = ST_R_OVF;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end

                // Then the character rule moves the state.
                state_next = st_mid;
                unique case (head_word.cls)
                    atrp_pkg::CC_O:
                    begin
                        state_next = (st_mid == ST_ERR) ? ST_ERRO : ST_O;
                    end
                    atrp_pkg::CC_K:
                    begin
                        state_next = (st_mid == ST_O) ? ST_OK : ST_IDLE;
                    end
                    atrp_pkg::CC_E:
                    begin
                        state_next = ST_E;
                    end
                    atrp_pkg::CC_R:
                    begin
                        if (st_mid == ST_E)
                        begin
                            state_next = ST_ER;
                        end
                        else if (st_mid == ST_ER)
                        begin
                            state_next = ST_ERR;
                        end
                        else if (st_mid == ST_ERRO)
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    atrp_pkg::CC_PLUS:
                    begin
                        state_next = ST_PLUS;
                    end
                    atrp_pkg::CC_I:
                    begin
                        if (st_mid == ST_PLUS)
                        begin
                            state_next = ST_PI;
                        end
                    end
                    atrp_pkg::CC_P:
                    begin
                        if (st_mid == ST_PI)
                        begin
                            state_next = ST_PIP;
                        end
                    end
                    atrp_pkg::CC_D:
                    begin
                        if (st_mid == ST_PIP)
                        begin
                            state_next = ST_DATA;
                        end
                        idx_next = '0;
                    end
                    atrp_pkg::CC_DASH:
                    begin
                        if (st_mid == ST_DATA)
                        begin
                            state_next = ST_R_MSG;
                        end
                        res_next.term_we   = 1'b1;
                        res_next.term_addr = atrp_pkg::ADDR_W'(idx_next);
                    end
                    default:
                    begin
                        state_next = st_mid;
                    end
                endcase
            end
        end

        // Report the outcome held after the step.
        unique case (state_next)
            ST_R_OK:  res_next.outcome = atrp_pkg::OC_OK;
            ST_R_ERR: res_next.outcome = atrp_pkg::OC_ERROR;
            ST_R_OVF: res_next.outcome = atrp_pkg::OC_OVERFLOW;
            ST_R_MSG: res_next.outcome = atrp_pkg::OC_MESSAGE;
            default:  res_next.outcome = atrp_pkg::OC_PENDING;
        endcase
    end

    // Parser state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                idx_reg   <= idx_next;
            end
            if (out_free)
            begin
                res_valid_reg <= pop;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### hdl/at_response_byte_parser.sv
// AT response byte parser: top level joining classifier, queue and parser core.
// A word accepted into the queue is applied by the parser core, which registers its result word.
// Throughput: one word per cycle while the result word is not stalled.
// While the result is stalled the two-entry queue takes up to two more words,
// then the input stalls until the result word is taken.
// Reset (rst_n, asynchronous, active low) sets the state to idle, the index
// to zero and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module at_response_byte_parser (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_valid,
    output logic                         cmd_stall,
    input  wire atrp_pkg::cmd_word_t     cmd,
    output logic                         res_valid,
    input  wire                          res_stall,
    output atrp_pkg::res_word_t          res
);

    atrp_pkg::class_word_t cls_word;
    atrp_pkg::class_word_t head_word;
    logic                  q_full;
    logic                  head_valid;
    logic                  pop;

    assign cmd_stall = q_full;

    // Classify the incoming word.
    atrp_front u_front (
        .cmd      (cmd),
        .cls_word (cls_word)
    );

    // Queue between classifier and parser core.
    atrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .push_word  (cls_word),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // Parser core with the result register.
    atrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire
